>>> src/hjq_pkg.sv
// hjq_pkg: types and constants of the HRRN job queue.
// No dependencies.
`default_nettype none
package hjq_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned SlotBits   = $clog2(QueueDepth);
  localparam int unsigned CountBits  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_HRRN = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_CMP,
    S_UNLINK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]          tag;
    logic [TimeBits-1:0] arr;
    logic [TimeBits-1:0] svc;
  } job_t;
endpackage
`default_nettype wire

>>> src/hrrn_job_queue_unit.sv
// hrrn_job_queue_unit: job queue with FIFO and highest-response-ratio dequeue.
// Depends on hjq_pkg.
//
// One request per start beat and one result strobe per request. Enqueue, a
// dequeue on an empty queue and a no-op give their result beat in the
// cycle right after start, and busy stays low. A dequeue walks the linked list
// through the job and link memories: the head through S_READ and S_MUL (memory
// read, latch), each further job of an HRRN walk through S_READ, S_MUL and
// S_CMP (memory read, cross multiply, compare), then S_UNLINK and S_DONE to
// unlink. The result beat is registered out of S_DONE and cannot be stalled by
// the receiver.
`default_nettype none
module hrrn_job_queue_unit (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        start,
  output logic              busy,
  input  wire  logic [1:0]  req_type_i,
  input  wire  logic [7:0]  job_tag_i,
  input  wire  logic [31:0] arrival_stamp_i,
  input  wire  logic [31:0] service_need_i,
  input  wire  logic [31:0] current_time_i,
  output logic              done,
  output logic              job_valid_o,
  output logic [7:0]        out_tag_o,
  output logic [31:0]       out_arrival_o,
  output logic [31:0]       out_service_o,
  output logic [1:0]        status_code_o,
  output logic [4:0]        occupancy_o
);
  import hjq_pkg::*;

  job_t                job_mem [QueueDepth];
  logic [SlotBits-1:0] link_mem [QueueDepth];

  state_e state_q, state_d;
  logic [QueueDepth-1:0] free_q, free_d;
  logic [SlotBits-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CountBits-1:0]  cnt_q, cnt_d;
  logic [1:0]            req_q;
  logic [TimeBits-1:0]   now_q;
  logic [SlotBits-1:0]   cur_q, cur_d, prev_q, prev_d, win_q, win_d, wprev_q, wprev_d;
  logic [CountBits-1:0]  idx_q, idx_d;
  logic [TimeBits-1:0]   bw_q, bw_d, bs_q, bs_d, w_q, s_q;
  logic [2*TimeBits-1:0] pa_q, pb_q;
  job_t                  win_job_q, win_job_d;
  job_t                  rd_job;
  logic [SlotBits-1:0]   rd_link, rd_addr;
  logic                  first_q, first_d;

  logic                  jwe, lwe;
  logic [SlotBits-1:0]   jwa, lwa, lwd;
  job_t                  jwd;
  logic                  mul_en;

  logic                  r_valid_d, r_done_d;
  logic [1:0]            r_status_d;

  logic [SlotBits-1:0]   free_slot;
  logic [TimeBits-1:0]   w_c, s_c;

  always_ff @(posedge clk_i) begin
    if (jwe) job_mem[jwa] <= jwd;
    if (lwe) link_mem[lwa] <= lwd;
    rd_job  <= job_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

  always_comb begin
    free_slot = '0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (free_q[i]) free_slot = SlotBits'(i);
    end
  end

  always_comb begin
    w_c = (now_q >= rd_job.arr) ? now_q - rd_job.arr : '0;
    s_c = (rd_job.svc == '0) ? TimeBits'(1) : rd_job.svc;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_type_i;
      now_q <= current_time_i[TimeBits-1:0];
    end
    if (mul_en) begin
      w_q  <= w_c;
      s_q  <= s_c;
      pa_q <= w_c * bs_q;
      pb_q <= bw_q * s_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_q  <= '1;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      done    <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      done    <= r_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    win_q     <= win_d;
    wprev_q   <= wprev_d;
    idx_q     <= idx_d;
    bw_q      <= bw_d;
    bs_q      <= bs_d;
    win_job_q <= win_job_d;
    first_q   <= first_d;
    if (r_done_d) begin
      job_valid_o   <= r_valid_d;
      status_code_o <= r_status_d;
      out_tag_o     <= r_valid_d ? win_job_d.tag : '0;
      out_arrival_o <= r_valid_d ? win_job_d.arr : '0;
      out_service_o <= r_valid_d ? win_job_d.svc : '0;
      occupancy_o   <= cnt_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    free_d = free_q; head_d = head_q; tail_d = tail_q; cnt_d = cnt_q;
    cur_d = cur_q; prev_d = prev_q; win_d = win_q; wprev_d = wprev_q;
    idx_d = idx_q; bw_d = bw_q; bs_d = bs_q; win_job_d = win_job_q; first_d = first_q;
    jwe = 1'b0; jwa = '0; jwd = '0;
    lwe = 1'b0; lwa = '0; lwd = '0;
    rd_addr = cur_q;
    mul_en = 1'b0;
    r_done_d = 1'b0; r_valid_d = 1'b0; r_status_d = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_type_i)
            REQ_ENQ: begin
              if (cnt_q == CountBits'(QueueDepth)) begin
                r_done_d = 1'b1; r_status_d = ST_FULL;
              end else begin
                jwe = 1'b1; jwa = free_slot;
                jwd.tag = job_tag_i;
                jwd.arr = arrival_stamp_i[TimeBits-1:0];
                jwd.svc = service_need_i[TimeBits-1:0];
                lwe = 1'b1;
                lwa = (cnt_q == '0) ? free_slot : tail_q;
                lwd = free_slot;
                if (cnt_q == '0) head_d = free_slot;
                tail_d = free_slot;
                free_d[free_slot] = 1'b0;
                cnt_d = cnt_q + 1'b1;
                r_done_d = 1'b1;
              end
            end
            REQ_DEQ, REQ_HRRN: begin
              if (cnt_q == '0) begin
                r_done_d = 1'b1; r_status_d = ST_EMPTY;
              end else begin
                cur_d = head_q; prev_d = head_q; win_d = head_q; wprev_d = head_q;
                idx_d = '0; first_d = 1'b1;
                state_d = S_READ;
              end
            end
            default: r_done_d = 1'b1;
          endcase
        end
      end
      S_READ: state_d = S_MUL;
      S_MUL: begin
        if (first_q) begin
          win_job_d = rd_job;
          bw_d = w_c; bs_d = s_c;
          first_d = 1'b0;
          if (req_q == REQ_DEQ || idx_q == cnt_q - 1'b1) begin
            state_d = S_UNLINK;
          end else begin
            prev_d = cur_q; cur_d = rd_link; idx_d = idx_q + 1'b1;
            state_d = S_READ;
          end
        end else begin
          mul_en = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (pa_q > pb_q) begin
          bw_d = w_q; bs_d = s_q; win_d = cur_q; wprev_d = prev_q;
          win_job_d = rd_job;
        end
        if (idx_q == cnt_q - 1'b1) begin
          rd_addr = win_d;
          state_d = S_UNLINK;
        end else begin
          prev_d = cur_q; cur_d = rd_link; idx_d = idx_q + 1'b1;
          rd_addr = rd_link;
          state_d = S_READ;
        end
      end
      S_UNLINK: begin
        rd_addr = win_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        rd_addr = win_q;
        if (win_q == head_q) begin
          head_d = rd_link;
        end else begin
          lwe = 1'b1; lwa = wprev_q; lwd = rd_link;
          if (win_q == tail_q) tail_d = wprev_q;
        end
        free_d[win_q] = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_d == '0) begin
          head_d = '0; tail_d = '0;
        end
        r_done_d = 1'b1; r_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !busy) else $error("result beat while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountBits'(QueueDepth)) else $error("count overflow");
  a_free_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_q) == QueueDepth - int'(cnt_q)) else $error("free map mismatch");
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_ENQ) |=> done) else $error("enqueue no result");
endmodule
`default_nettype wire

>>> test/tb_hrrn_job_queue_unit.sv
// tb_hrrn_job_queue_unit: self-checking bench for the HRRN job queue unit.
// Drives enqueue, FIFO and HRRN dequeue beats and checks each result beat
// against an in-bench model of the linked job list. Depends on hjq_pkg.
`timescale 1ns / 1ps
module tb_hrrn_job_queue_unit;
  import hjq_pkg::*;

  typedef struct {
    req_e        req;
    logic [7:0]  tag;
    logic [31:0] arr;
    logic [31:0] svc;
    logic [31:0] now;
  } beat_t;

  typedef struct {
    logic        vld;
    logic [7:0]  tag;
    logic [31:0] arr;
    logic [31:0] svc;
    status_e     st;
    logic [4:0]  occ;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  req_type_i = '0;
  logic [7:0]  job_tag_i = '0;
  logic [31:0] arrival_stamp_i = '0;
  logic [31:0] service_need_i = '0;
  logic [31:0] current_time_i = '0;
  logic        busy, done, job_valid_o;
  logic [7:0]  out_tag_o;
  logic [31:0] out_arrival_o, out_service_o;
  logic [1:0]  status_code_o;
  logic [4:0]  occupancy_o;

  hrrn_job_queue_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .job_tag_i, .arrival_stamp_i,
    .service_need_i, .current_time_i, .done, .job_valid_o, .out_tag_o,
    .out_arrival_o, .out_service_o, .status_code_o, .occupancy_o
  );

  always #2 clk_i = ~clk_i;

  // model state: slots, links, free map
  job_t             q_job [QueueDepth];
  logic [SlotBits-1:0] q_link [QueueDepth];
  bit               q_free [QueueDepth];
  int unsigned      q_head, q_tail, q_cnt;

  beat_t pending_q[$];
  res_t  expected_q[$];
  int    errors = 0, n_results = 0, n_hrrn_hits = 0, n_full = 0, n_empty = 0;
  bit    stim_done = 0;

  function automatic res_t queue_apply(beat_t b);
    res_t r;
    int unsigned slot, win, win_prev, prev, cur;
    logic [63:0] bw, bs, w, s;
    r = '{vld: 0, tag: 0, arr: 0, svc: 0, st: ST_OK, occ: 0};
    if (b.req == REQ_ENQ) begin
      if (q_cnt >= QueueDepth) begin
        r.st = ST_FULL;
      end else begin
        slot = 0;
        for (int i = QueueDepth - 1; i >= 0; i--) if (q_free[i]) slot = i;
        q_free[slot] = 0;
        q_job[slot] = '{tag: b.tag, arr: b.arr, svc: b.svc};
        q_link[slot] = '0;
        if (q_cnt == 0) q_head = slot;
        else q_link[q_tail] = slot;
        q_tail = slot;
        q_cnt++;
      end
    end else if (b.req == REQ_DEQ || b.req == REQ_HRRN) begin
      if (q_cnt == 0) begin
        r.st = ST_EMPTY;
      end else begin
        win = q_head;
        win_prev = win;
        if (b.req == REQ_HRRN) begin
          cur = win;
          bw = (b.now >= q_job[win].arr) ? 64'(b.now - q_job[win].arr) : 64'd0;
          bs = (q_job[win].svc == 0) ? 64'd1 : 64'(q_job[win].svc);
          for (int i = 1; i < q_cnt; i++) begin
            prev = cur;
            cur = q_link[cur];
            w = (b.now >= q_job[cur].arr) ? 64'(b.now - q_job[cur].arr) : 64'd0;
            s = (q_job[cur].svc == 0) ? 64'd1 : 64'(q_job[cur].svc);
            if (w * bs > bw * s) begin
              bw = w; bs = s; win = cur; win_prev = prev;
            end
          end
        end
        r.vld = 1;
        r.tag = q_job[win].tag;
        r.arr = q_job[win].arr;
        r.svc = q_job[win].svc;
        if (win == q_head) begin
          q_head = q_link[win];
        end else begin
          q_link[win_prev] = q_link[win];
          if (win == q_tail) q_tail = win_prev;
        end
        q_free[win] = 1;
        q_cnt--;
        if (q_cnt == 0) begin
          q_head = 0; q_tail = 0;
        end
      end
    end
    r.occ = 5'(q_cnt);
    return r;
  endfunction

  function automatic beat_t mk(req_e rq, logic [7:0] t, logic [31:0] a, logic [31:0] s,
                               logic [31:0] n);
    beat_t b;
    b.req = rq; b.tag = t; b.arr = a; b.svc = s; b.now = n;
    return b;
  endfunction

  // driver: bursts and gaps
  int gap_left = 0, burst_left = 0;
  beat_t cur_b;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_q.push_back(queue_apply(cur_b));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_b = pending_q.pop_front();
          start <= 1'b1;
          req_type_i <= cur_b.req;
          job_tag_i <= cur_b.tag;
          arrival_stamp_i <= cur_b.arr;
          service_need_i <= cur_b.svc;
          current_time_i <= cur_b.now;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
          stim_done = 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && done) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result beat");
      end else begin
        e = expected_q.pop_front();
        if (job_valid_o !== e.vld || out_tag_o !== e.tag || out_arrival_o !== e.arr ||
            out_service_o !== e.svc || status_code_o !== e.st ||
            occupancy_o !== e.occ) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: exp v%0d t%0h a%0h s%0h st%0d o%0d got v%0d t%0h a%0h s%0h st%0d o%0d",
                     e.vld, e.tag, e.arr, e.svc, e.st, e.occ, job_valid_o, out_tag_o,
                     out_arrival_o, out_service_o, status_code_o, occupancy_o);
        end
        if (e.vld) n_hrrn_hits++;
        if (e.st == ST_FULL) n_full++;
        if (e.st == ST_EMPTY) n_empty++;
      end
    end
  end

  function automatic logic [31:0] rnd_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 40);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, fill;
    logic [31:0] base;
    for (int i = 0; i < QueueDepth; i++) begin
      q_free[i] = 1; q_link[i] = '0; q_job[i] = '0;
    end
    q_head = 0; q_tail = 0; q_cnt = 0;
    // directed: empty dequeues, fill past full, HRRN ties, zero service, future arrival
    pending_q.push_back(mk(REQ_DEQ, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_HRRN, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_NOP, 8'hFF, '1, '1, '1));
    for (int i = 0; i < 17; i++)
      pending_q.push_back(mk(REQ_ENQ, 8'(i * 15), (i % 2) ? 32'hFFFF_FFFF : 32'd0,
                             (i % 3 == 0) ? 32'd0 : ((i % 3 == 1) ? 32'hFFFF_FFFF : 32'd5),
                             0));
    pending_q.push_back(mk(REQ_HRRN, 0, 0, 0, 32'd100));
    pending_q.push_back(mk(REQ_HRRN, 0, 0, 0, 32'hFFFF_FFFF));
    pending_q.push_back(mk(REQ_DEQ, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_HRRN, 0, 0, 0, 0));
    // random: mostly enqueue/dequeue sequences with random content
    n = 0;
    while (n < 550) begin
      fill = $urandom_range(1, 16);
      base = $urandom;
      for (int i = 0; i < fill; i++) begin
        pending_q.push_back(mk(REQ_ENQ, 8'($urandom), ($urandom_range(0, 4) == 0) ?
                               rnd_time() : base + $urandom_range(0, 100),
                               ($urandom_range(0, 5) == 0) ? rnd_time() :
                               $urandom_range(0, 50), 0));
        n++;
      end
      for (int i = 0; i < $urandom_range(1, 18); i++) begin
        pending_q.push_back(mk(req_e'($urandom_range(0, 7) == 0 ? REQ_DEQ :
                               ($urandom_range(0, 15) == 0 ? REQ_NOP : REQ_HRRN)),
                               8'($urandom), $urandom, $urandom,
                               ($urandom_range(0, 3) == 0) ? rnd_time() :
                               base + $urandom_range(0, 300)));
        n++;
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_q.size() == 0 && !busy);
    repeat (60) @(posedge clk_i);
    $display("Checked %0d result beats: %0d jobs removed, %0d full, %0d empty.",
             n_results, n_hrrn_hits, n_full, n_empty);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d, left over: %0d", errors, expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end
endmodule
